// File: sv/ntbp_pkg.sv
// ntbp_pkg: shared types and constants for the nucleotide two-bit packer
// no dependencies; imported by every module of the block

package ntbp_pkg;

   // ascii codes of the four bases, upper and lower case
   localparam logic [7:0] CHAR_A_UP = 8'd65;
   localparam logic [7:0] CHAR_A_LO = 8'd97;
   localparam logic [7:0] CHAR_C_UP = 8'd67;
   localparam logic [7:0] CHAR_C_LO = 8'd99;
   localparam logic [7:0] CHAR_G_UP = 8'd71;
   localparam logic [7:0] CHAR_G_LO = 8'd103;
   localparam logic [7:0] CHAR_T_UP = 8'd84;
   localparam logic [7:0] CHAR_T_LO = 8'd116;

   // two-bit base codes
   localparam logic [1:0] CODE_A = 2'd0;
   localparam logic [1:0] CODE_C = 2'd1;
   localparam logic [1:0] CODE_G = 2'd2;
   localparam logic [1:0] CODE_T = 2'd3;

   localparam int WORD_BITS  = 32;
   localparam int WORD_SLOTS = WORD_BITS / 2;

   // input transaction
   typedef struct packed {
      logic [7:0] base_char;
      logic       final_char;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [WORD_BITS-1:0] packed_word;
      logic                 last_word;
   } rsp_type;

   // decoded base
   typedef struct packed {
      logic       hit;
      logic [1:0] code;
   } base_type;

   // result handed from the packer to the output buffer
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

// File: sv/nucleotide_two_bit_packer.sv
// nucleotide_two_bit_packer: top level, packs dna characters into 32-bit words
// depends on ntbp_pkg, ntbp_packer, ntbp_base_decode and ntbp_out_buffer
//
// channel   ports                          direction  payload
// request   req_valid req_stall req_data   in         req_type (base_char, final_char)
// response  rsp_valid rsp_stall rsp_data   out        rsp_type (packed_word, last_word)
//
// one character is taken every cycle while req_stall is low; the word that a
// closing character completes goes to the result register, or to the skid entry
// while the output stalls. the decode and slot insert sit between the state
// registers and the result register. reset is synchronous and clears all group
// state and both output entries. a one-entry skid behind the result register
// absorbs a stalled word; req_stall is a register output and rises only once that skid entry is full.

module nucleotide_two_bit_packer
   import ntbp_pkg::*;
#(
   parameter int BASES_PER_WORD = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic       req_accept;
   logic       skid_full;
   result_type result;

   assign req_stall  = skid_full;
   assign req_accept = req_valid && !req_stall;

   ntbp_packer #(
      .BASES_PER_WORD (BASES_PER_WORD)
   ) u_packer (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_data (req_data),
      .result   (result)
   );

   ntbp_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .skid_full (skid_full)
   );

   // skid entry only fills behind a held output
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("skid entry full with output register empty");

   // a final character always produces a word by the next cycle
   a_final_emits: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.final_char |=> rsp_valid)
      else $error("final character produced no word");

   // a produced result never meets a full skid with a stalled output
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> !skid_full)
      else $error("result arrived while output buffer full");

endmodule

// File: sv/ntbp_base_decode.sv
// ntbp_base_decode: maps an ascii character to a two-bit base code
// depends on ntbp_pkg

module ntbp_base_decode
   import ntbp_pkg::*;
(
   input  logic [7:0] base_char,
   output base_type   base
);

   // character decoder, anything that is not a base gives no hit
   always_comb begin
      base = '0;
      unique case (base_char) inside
         CHAR_A_UP, CHAR_A_LO: begin
            base.hit  = 1'b1;
            base.code = CODE_A;
         end
         CHAR_C_UP, CHAR_C_LO: begin
            base.hit  = 1'b1;
            base.code = CODE_C;
         end
         CHAR_G_UP, CHAR_G_LO: begin
            base.hit  = 1'b1;
            base.code = CODE_G;
         end
         CHAR_T_UP, CHAR_T_LO: begin
            base.hit  = 1'b1;
            base.code = CODE_T;
         end
         default: begin
            base = '0;
         end
      endcase
   end

endmodule

// File: sv/ntbp_packer.sv
// ntbp_packer: group position, valid count and word accumulator state
// depends on ntbp_pkg and ntbp_base_decode

module ntbp_packer
   import ntbp_pkg::*;
#(
   parameter int BASES_PER_WORD = 16
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req_data,
   output result_type result
);

   localparam int PW    = $clog2(BASES_PER_WORD + 1);
   localparam int SLOTS = (BASES_PER_WORD < WORD_SLOTS) ? BASES_PER_WORD : WORD_SLOTS;

   logic [PW-1:0]        group_position_ff, group_position_in;
   logic [PW-1:0]        valid_count_ff, valid_count_in;
   logic [WORD_BITS-1:0] word_accumulator_ff, word_accumulator_in;
   logic [WORD_BITS-1:0] word_next;
   logic                 end_group;
   base_type             base;

   ntbp_base_decode u_decode (
      .base_char (req_data.base_char),
      .base      (base)
   );

   // drop the new code into the slot given by the valid count
   always_comb begin
      word_next = word_accumulator_ff;
      for (int i = 0; i < SLOTS; i++) begin
         if (base.hit && (valid_count_ff == PW'(i))) begin
            word_next[2*i +: 2] = base.code;
         end
      end
   end

   assign end_group = (group_position_ff == PW'(BASES_PER_WORD - 1)) || req_data.final_char;

   // next state and result
   always_comb begin
      group_position_in   = group_position_ff;
      valid_count_in      = valid_count_ff;
      word_accumulator_in = word_accumulator_ff;
      result              = '0;
      if (accept) begin
         if (end_group) begin
            result.valid            = 1'b1;
            result.data.packed_word = word_next;
            result.data.last_word   = req_data.final_char;
            group_position_in       = '0;
            valid_count_in          = '0;
            word_accumulator_in     = '0;
         end else begin
            group_position_in   = group_position_ff + PW'(1);
            valid_count_in      = valid_count_ff + PW'(base.hit);
            word_accumulator_in = word_next;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         group_position_ff   <= '0;
         valid_count_ff      <= '0;
         word_accumulator_ff <= '0;
      end else begin
         group_position_ff   <= group_position_in;
         valid_count_ff      <= valid_count_in;
         word_accumulator_ff <= word_accumulator_in;
      end
   end

endmodule

// File: sv/ntbp_out_buffer.sv
// ntbp_out_buffer: result register with one skid entry behind it
// depends on ntbp_pkg

module ntbp_out_buffer
   import ntbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   output logic       skid_full
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   // refill output from skid first, else packer; stalled results go to skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = result.valid;
            out_data_in  = result.data;
         end
      end else if (result.valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result.data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign skid_full = skid_valid_ff;

endmodule
